>>> sv/bba_pkg.sv
// Shared types, constants and helpers for the buddy block allocator.
`default_nettype none
package bba_pkg;

    localparam int NUM_ORDERS      = 11;
    localparam int MIN_BLOCK_BYTES = 32;
    localparam int TOP_ORDER       = NUM_ORDERS - 1;
    localparam int POOL_UNITS      = 1 << TOP_ORDER;
    localparam int MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);

    localparam int OFF_W  = 10;
    localparam int LINK_W = 11;
    localparam int ORD_W  = 4;
    localparam int BYTE_W = 16;
    localparam int REQ_W  = 17;

    localparam logic [LINK_W-1:0] NIL       = LINK_W'(POOL_UNITS);
    localparam logic [REQ_W-1:0]  POOL_BYTES = REQ_W'(MIN_BLOCK_BYTES << TOP_ORDER);
    localparam logic [ORD_W-1:0]  TOP_ORD   = ORD_W'(TOP_ORDER);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_GROW  = 2'd2;
    localparam logic [1:0] CMD_BAD   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_TOOBIG  = 2'd2;

    // Per-unit bookkeeping word kept in one memory
    typedef struct packed {
        logic             used;
        logic             onl;
        logic [ORD_W-1:0] ord;
    } meta_t;

    // Bytes in a block of the given order
    function automatic logic [REQ_W-1:0] ord_bytes(input logic [ORD_W-1:0] o);
        ord_bytes = REQ_W'(MIN_BLOCK_BYTES) << o;
    endfunction

endpackage
`default_nettype wire

>>> sv/bba_order_calc.sv
// Rounds a total byte count up to a block order and flags oversize requests.
`default_nettype none
module bba_order_calc (
    input  wire logic                       clk,
    input  wire logic [bba_pkg::REQ_W-1:0]  total,
    output logic      [bba_pkg::ORD_W-1:0]  ord_reg,
    output logic                            too_big_reg
);
    import bba_pkg::*;

    logic [REQ_W-1:0] tm1;
    logic [ORD_W:0]   msb;
    logic [ORD_W-1:0] ord_next;

    // Find the top set bit of total minus one
    always_comb
    begin
        tm1 = total - REQ_W'(1);
        msb = '0;
        for (int i = 0; i < REQ_W; i++)
        begin
            if (tm1[i])
            begin
                msb = (ORD_W+1)'(i + 1);
            end
        end
        if (total <= REQ_W'(MIN_BLOCK_BYTES))
        begin
            ord_next = '0;
        end
        else
        begin
            ord_next = ORD_W'(msb - (ORD_W+1)'(MIN_SHIFT));
        end
    end

    // Register the order and the oversize flag
    always_ff @(posedge clk)
    begin
        ord_reg     <= ord_next;
        too_big_reg <= (total > POOL_BYTES);
    end

endmodule
`default_nettype wire

>>> sv/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: command sequencer and state memories.
//
// Commands enter on the s_ stream (allocate, free, grow in place); every
// command yields one result beat on the m_ stream. The user must write
// header_bytes on the cfg_ channel only while the block is idle; the block
// itself does not enforce this, and cfg_ready is always high. The
// sequencer handles one command at a time. An allocate splits its block
// down order by order, a free merges it upward with free buddies, and a
// grow absorbs higher buddies. A list removal passes through S_RM0 and
// S_RM1, an insertion through S_PS0 and S_PS1, and each buddy probe reads
// the bookkeeping memory before it checks the word; the single read port
// of that memory sets the pace.
// A finished result sits in an output register, so the next command is
// taken while the receiver stalls; the sequencer only waits when a second
// result is ready and the first is still held.
// After reset a clearing pass over all 1024 units initializes the memories;
// s_tready stays low until it ends.
`default_nettype none
module buddy_block_allocator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // cmd[1:0], request_bytes[17:2], block_offset[27:18]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // status[1:0], result_offset[11:2],
                                        // usable_bytes[27:12], bytes_in_use[43:28]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    import bba_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CALC,
        S_A0, S_A1,
        S_F0, S_F1, S_F2, S_F3, S_F4,
        S_G0, S_G1, S_G2, S_G3, S_G4,
        S_RM0, S_RM1, S_PS0, S_PS1,
        S_DONE
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [OFF_W-1:0]  clr_reg, clr_next;
    logic [4:0]        hdr_reg;
    logic [1:0]        cmd_reg, cmd_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [ORD_W-1:0]  cur_reg, cur_next;
    logic [ORD_W-1:0]  base_reg, base_next;
    logic [ORD_W-1:0]  iter_reg, iter_next;
    logic [OFF_W-1:0]  blk_reg, blk_next;
    logic [OFF_W-1:0]  rm_off_reg, rm_off_next;
    logic [OFF_W-1:0]  ps_off_reg, ps_off_next;
    logic [ORD_W-1:0]  ps_o_reg, ps_o_next;
    logic [LINK_W-1:0] ps_h_reg, ps_h_next;
    logic [BYTE_W-1:0] bytes_reg, bytes_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    logic [BYTE_W-1:0] res_use_reg, res_use_next;
    logic              mv_reg, mv_next;
    logic [47:0]       mdata_reg, mdata_next;

    // Free list heads
    logic [LINK_W-1:0] head_reg [NUM_ORDERS];
    logic              hd_we;
    logic [ORD_W-1:0]  hd_idx;
    logic [LINK_W-1:0] hd_wdata;

    // Memories
    meta_t             meta_mem [POOL_UNITS];
    logic [LINK_W-1:0] nxt_mem  [POOL_UNITS];
    logic [LINK_W-1:0] prv_mem  [POOL_UNITS];
    meta_t             meta_rd;
    logic [LINK_W-1:0] nxt_rd, prv_rd;
    logic              meta_we, nxt_we, prv_we;
    logic [OFF_W-1:0]  meta_raddr, meta_waddr, nxt_waddr, prv_waddr;
    meta_t             meta_wdata;
    logic [LINK_W-1:0] nxt_wdata, prv_wdata;

    logic [ORD_W-1:0]  calc_ord;
    logic              calc_big;
    logic              s_acc;
    logic              found;
    logic [ORD_W-1:0]  found_ord;
    logic [OFF_W-1:0]  bud;
    logic [REQ_W-1:0]  use_wide;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;

    bba_order_calc u_calc (
        .clk         (clk),
        .total       (req_reg),
        .ord_reg     (calc_ord),
        .too_big_reg (calc_big)
    );

    // Smallest non-empty order at or above the needed one
    always_comb
    begin
        found     = 1'b0;
        found_ord = '0;
        for (int i = NUM_ORDERS - 1; i >= 0; i--)
        begin
            if (ORD_W'(i) >= calc_ord && head_reg[i] != NIL)
            begin
                found     = 1'b1;
                found_ord = ORD_W'(i);
            end
        end
    end

    // Sequencer next state and memory controls
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        clr_next     = clr_reg;
        cmd_next     = cmd_reg;
        req_next     = req_reg;
        off_next     = off_reg;
        cur_next     = cur_reg;
        base_next    = base_reg;
        iter_next    = iter_reg;
        blk_next     = blk_reg;
        rm_off_next  = rm_off_reg;
        ps_off_next  = ps_off_reg;
        ps_o_next    = ps_o_reg;
        ps_h_next    = ps_h_reg;
        bytes_next   = bytes_reg;
        res_st_next  = res_st_reg;
        res_off_next = res_off_reg;
        res_use_next = res_use_reg;
        mv_next      = mv_reg && !m_tready;
        mdata_next   = mdata_reg;
        hd_we        = 1'b0;
        hd_idx       = '0;
        hd_wdata     = NIL;
        meta_we      = 1'b0;
        meta_waddr   = '0;
        meta_wdata   = '0;
        meta_raddr   = off_reg;
        nxt_we       = 1'b0;
        nxt_waddr    = '0;
        nxt_wdata    = NIL;
        prv_we       = 1'b0;
        prv_waddr    = '0;
        prv_wdata    = NIL;
        bud          = off_reg ^ (OFF_W'(1) << cur_reg);
        use_wide     = '0;

        case (state_reg)
            // Sweep the memories once after reset
            S_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = (clr_reg == '0) ? meta_t'{used: 1'b0, onl: 1'b1, ord: TOP_ORD}
                                             : meta_t'(0);
                nxt_we     = 1'b1;
                nxt_waddr  = clr_reg;
                prv_we     = 1'b1;
                prv_waddr  = clr_reg;
                clr_next   = clr_reg + OFF_W'(1);
                if (clr_reg == OFF_W'(POOL_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_acc)
                begin
                    cmd_next     = s_tdata[1:0];
                    req_next     = REQ_W'(s_tdata[17:2]) + REQ_W'(hdr_reg);
                    off_next     = s_tdata[27:18];
                    res_st_next  = ST_NOSPACE;
                    res_off_next = '0;
                    res_use_next = '0;
                    state_next   = S_CALC;
                end
            end
            S_CALC:
            begin
                case (cmd_reg)
                    CMD_ALLOC: state_next = S_A0;
                    CMD_FREE:  state_next = S_F0;
                    CMD_GROW:  state_next = S_G0;
                    default:   state_next = S_DONE;
                endcase
            end
            // Allocate: take a head, then split down
            S_A0:
            begin
                if (calc_big)
                begin
                    res_st_next = ST_TOOBIG;
                    state_next  = S_DONE;
                end
                else if (!found)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    blk_next    = head_reg[found_ord][OFF_W-1:0];
                    rm_off_next = head_reg[found_ord][OFF_W-1:0];
                    cur_next    = found_ord;
                    ret_next    = S_A1;
                    state_next  = S_RM0;
                end
            end
            S_A1:
            begin
                if (cur_reg != calc_ord)
                begin
                    ps_o_next   = cur_reg - ORD_W'(1);
                    ps_off_next = blk_reg | (OFF_W'(1) << (cur_reg - ORD_W'(1)));
                    cur_next    = cur_reg - ORD_W'(1);
                    ret_next    = S_A1;
                    state_next  = S_PS0;
                end
                else
                begin
                    meta_we      = 1'b1;
                    meta_waddr   = blk_reg;
                    meta_wdata   = '{used: 1'b1, onl: 1'b0, ord: calc_ord};
                    bytes_next   = bytes_reg + BYTE_W'(ord_bytes(calc_ord));
                    use_wide     = ord_bytes(calc_ord) - REQ_W'(hdr_reg);
                    res_st_next  = ST_OK;
                    res_off_next = blk_reg;
                    res_use_next = use_wide[BYTE_W-1:0];
                    state_next   = S_DONE;
                end
            end
            // Free: release, then merge upward
            S_F0:
            begin
                meta_raddr = off_reg;
                state_next = S_F1;
            end
            S_F1:
            begin
                if (!meta_rd.used)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    meta_we    = 1'b1;
                    meta_waddr = off_reg;
                    meta_wdata = '{used: 1'b0, onl: 1'b0, ord: meta_rd.ord};
                    bytes_next = bytes_reg - BYTE_W'(ord_bytes(meta_rd.ord));
                    cur_next   = meta_rd.ord;
                    state_next = S_F2;
                end
            end
            S_F2:
            begin
                if (cur_reg == TOP_ORD)
                begin
                    ps_off_next = off_reg;
                    ps_o_next   = cur_reg;
                    ret_next    = S_F4;
                    state_next  = S_PS0;
                end
                else
                begin
                    meta_raddr = bud;
                    state_next = S_F3;
                end
            end
            S_F3:
            begin
                if (meta_rd.onl && meta_rd.ord == cur_reg)
                begin
                    rm_off_next = bud;
                    off_next    = off_reg & ~(OFF_W'(1) << cur_reg);
                    cur_next    = cur_reg + ORD_W'(1);
                    ret_next    = S_F2;
                    state_next  = S_RM0;
                end
                else
                begin
                    ps_off_next = off_reg;
                    ps_o_next   = cur_reg;
                    ret_next    = S_F4;
                    state_next  = S_PS0;
                end
            end
            S_F4:
            begin
                res_st_next  = ST_OK;
                res_off_next = off_reg;
                state_next   = S_DONE;
            end
            // Grow: probe higher buddies, then absorb them
            S_G0:
            begin
                meta_raddr = off_reg;
                state_next = S_G1;
            end
            S_G1:
            begin
                if (!meta_rd.used)
                begin
                    state_next = S_DONE;
                end
                else if (calc_big)
                begin
                    res_st_next = ST_TOOBIG;
                    state_next  = S_DONE;
                end
                else
                begin
                    base_next  = meta_rd.ord;
                    cur_next   = meta_rd.ord;
                    state_next = S_G2;
                end
            end
            S_G2:
            begin
                if (cur_reg < TOP_ORD && ord_bytes(cur_reg) < req_reg)
                begin
                    if (bud < off_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        meta_raddr = bud;
                        state_next = S_G3;
                    end
                end
                else
                begin
                    iter_next  = base_reg;
                    state_next = S_G4;
                end
            end
            S_G3:
            begin
                if (meta_rd.onl && meta_rd.ord == cur_reg)
                begin
                    cur_next   = cur_reg + ORD_W'(1);
                    state_next = S_G2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_G4:
            begin
                if (iter_reg != cur_reg)
                begin
                    rm_off_next = off_reg | (OFF_W'(1) << iter_reg);
                    iter_next   = iter_reg + ORD_W'(1);
                    ret_next    = S_G4;
                    state_next  = S_RM0;
                end
                else
                begin
                    meta_we      = 1'b1;
                    meta_waddr   = off_reg;
                    meta_wdata   = '{used: 1'b1, onl: 1'b0, ord: cur_reg};
                    use_wide     = ord_bytes(cur_reg) - ord_bytes(base_reg);
                    bytes_next   = bytes_reg + use_wide[BYTE_W-1:0];
                    use_wide     = ord_bytes(cur_reg) - REQ_W'(hdr_reg);
                    res_st_next  = ST_OK;
                    res_off_next = off_reg;
                    res_use_next = use_wide[BYTE_W-1:0];
                    state_next   = S_DONE;
                end
            end
            // Unlink one free block
            S_RM0:
            begin
                meta_raddr = rm_off_reg;
                state_next = S_RM1;
            end
            S_RM1:
            begin
                meta_we    = 1'b1;
                meta_waddr = rm_off_reg;
                meta_wdata = '{used: 1'b0, onl: 1'b0, ord: meta_rd.ord};
                if (nxt_rd != NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rd[OFF_W-1:0];
                    prv_wdata = prv_rd;
                end
                if (prv_rd != NIL)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rd[OFF_W-1:0];
                    nxt_wdata = nxt_rd;
                end
                else
                begin
                    hd_we    = 1'b1;
                    hd_idx   = meta_rd.ord;
                    hd_wdata = nxt_rd;
                end
                state_next = ret_reg;
            end
            // Link one free block at the head of its list
            S_PS0:
            begin
                ps_h_next  = head_reg[ps_o_reg];
                nxt_we     = 1'b1;
                nxt_waddr  = ps_off_reg;
                nxt_wdata  = head_reg[ps_o_reg];
                prv_we     = 1'b1;
                prv_waddr  = ps_off_reg;
                prv_wdata  = NIL;
                meta_we    = 1'b1;
                meta_waddr = ps_off_reg;
                meta_wdata = '{used: 1'b0, onl: 1'b1, ord: ps_o_reg};
                hd_we      = 1'b1;
                hd_idx     = ps_o_reg;
                hd_wdata   = LINK_W'(ps_off_reg);
                state_next = S_PS1;
            end
            S_PS1:
            begin
                if (ps_h_reg != NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = ps_h_reg[OFF_W-1:0];
                    prv_wdata = LINK_W'(ps_off_reg);
                end
                state_next = ret_reg;
            end
            // Hand the result to the output register
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mdata_next = {4'd0, bytes_reg, res_use_reg, res_off_reg, res_st_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_IDLE;
            clr_reg   <= '0;
            hdr_reg   <= 5'd8;
            bytes_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
            bytes_reg <= bytes_next;
            mv_reg    <= mv_next;
            if (cfg_valid)
            begin
                hdr_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        req_reg     <= req_next;
        off_reg     <= off_next;
        cur_reg     <= cur_next;
        base_reg    <= base_next;
        iter_reg    <= iter_next;
        blk_reg     <= blk_next;
        rm_off_reg  <= rm_off_next;
        ps_off_reg  <= ps_off_next;
        ps_o_reg    <= ps_o_next;
        ps_h_reg    <= ps_h_next;
        res_st_reg  <= res_st_next;
        res_off_reg <= res_off_next;
        res_use_reg <= res_use_next;
        mdata_reg   <= mdata_next;
    end

    // List heads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ORDERS; i++)
            begin
                head_reg[i] <= (i == TOP_ORDER) ? LINK_W'(0) : NIL;
            end
        end
        else if (hd_we)
        begin
            head_reg[hd_idx] <= hd_wdata;
        end
    end

    // Bookkeeping memory
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rd <= meta_mem[meta_raddr];
    end

    // Forward link memory
    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        nxt_rd <= nxt_mem[rm_off_reg];
    end

    // Backward link memory
    always_ff @(posedge clk)
    begin
        if (prv_we)
        begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
        prv_rd <= prv_mem[rm_off_reg];
    end

    // A beat accepted leaves the idle state at once
    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_tready)
        else $error("input taken while sequencer busy");

    // The byte count moves only while a command is worked
    a_bytes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_CLEAR) |=> $stable(bytes_reg))
        else $error("byte count changed outside a command");

    // No list head changes during the clearing sweep
    a_clear_heads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !hd_we)
        else $error("list head written during clearing");

    // A result is loaded only when the output register is free
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && mv_reg && !m_tready) |=> state_reg == S_DONE)
        else $error("result dropped while output stalled");

endmodule
`default_nettype wire

>>> verif/buddy_block_allocator_top_test.sv
// Self-checking testbench for the buddy block allocator top level.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_top_test;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;

    // Fields from the highest bit down, matching the result beat layout
    typedef struct packed {
        logic [BYTE_W-1:0] held;
        logic [BYTE_W-1:0] usable;
        logic [OFF_W-1:0]  offset;
        logic [1:0]        status;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    // Allocator shadow state
    int          head_of[NUM_ORDERS];
    int          link_next[POOL_UNITS];
    int          link_prev[POOL_UNITS];
    int          order_at[POOL_UNITS];
    bit          used_at[POOL_UNITS];
    bit          listed_at[POOL_UNITS];
    logic [15:0] bytes_out;
    int          hdr_len;

    grant_t      grants_due[$];
    int          live_blocks[$];
    int          errors = 0;
    int          cycles = 0;
    bit          hold_req = 1'b0;
    bit          no_gaps = 1'b0;

    buddy_block_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("buddy_block_allocator_top_test: done, errors");
            $finish;
        end
    end

    function automatic int blk_bytes(input int o);
        return MIN_BLOCK_BYTES << o;
    endfunction

    function automatic void list_add(input int off, input int o);
        int h;
        h = head_of[o];
        link_next[off] = h;
        if (h != POOL_UNITS)
            link_prev[h] = off;
        link_prev[off] = POOL_UNITS;
        head_of[o] = off;
        order_at[off] = o;
        listed_at[off] = 1'b1;
    endfunction

    function automatic void list_drop(input int off);
        int n;
        int p;
        n = link_next[off];
        p = link_prev[off];
        if (n != POOL_UNITS)
            link_prev[n] = p;
        if (p != POOL_UNITS)
            link_next[p] = n;
        else
            head_of[order_at[off]] = n;
        listed_at[off] = 1'b0;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < POOL_UNITS; i++)
        begin
            link_next[i] = 0;
            link_prev[i] = 0;
            order_at[i] = 0;
            used_at[i] = 1'b0;
            listed_at[i] = 1'b0;
        end
        for (int o = 0; o < NUM_ORDERS; o++)
            head_of[o] = POOL_UNITS;
        list_add(0, TOP_ORDER);
        bytes_out = '0;
        hdr_len = 8;
    endfunction

    // Apply one command to the shadow state and return its grant
    function automatic grant_t allocator_step(input logic [1:0] cmd, input int req_in,
                                              input int off_in);
        grant_t g;
        int     need;
        int     off;
        int     o;
        int     b;
        int     t;
        int     blk;
        int     bud;
        bit     ok;
        g = '{status: ST_NOSPACE, offset: '0, usable: '0, held: '0};
        need = req_in + hdr_len;
        off = off_in;
        if (cmd == CMD_ALLOC)
        begin
            if (need > blk_bytes(TOP_ORDER))
                g.status = ST_TOOBIG;
            else
            begin
                o = 0;
                while (blk_bytes(o) < need)
                    o++;
                b = o;
                while (b < NUM_ORDERS && head_of[b] == POOL_UNITS)
                    b++;
                if (b < NUM_ORDERS)
                begin
                    blk = head_of[b];
                    list_drop(blk);
                    while (b > o)
                    begin
                        b--;
                        list_add(blk + (1 << b), b);
                    end
                    order_at[blk] = o;
                    used_at[blk] = 1'b1;
                    bytes_out += 16'(blk_bytes(o));
                    g.status = ST_OK;
                    g.offset = OFF_W'(blk);
                    g.usable = 16'(blk_bytes(o) - hdr_len);
                    live_blocks.push_back(blk);
                end
            end
        end
        else if (cmd == CMD_FREE)
        begin
            if (used_at[off])
            begin
                o = order_at[off];
                used_at[off] = 1'b0;
                bytes_out -= 16'(blk_bytes(o));
                for (int i = 0; i < live_blocks.size(); i++)
                    if (live_blocks[i] == off)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
                while (o < TOP_ORDER)
                begin
                    bud = off ^ (1 << o);
                    if (!listed_at[bud] || order_at[bud] != o)
                        break;
                    list_drop(bud);
                    off &= ~(1 << o);
                    o++;
                end
                list_add(off, o);
                g.status = ST_OK;
                g.offset = OFF_W'(off);
            end
        end
        else if (cmd == CMD_GROW)
        begin
            if (used_at[off])
            begin
                if (need > blk_bytes(TOP_ORDER))
                    g.status = ST_TOOBIG;
                else
                begin
                    ok = 1'b1;
                    o = order_at[off];
                    t = o;
                    while (t < TOP_ORDER && blk_bytes(t) < need)
                    begin
                        bud = off ^ (1 << t);
                        if (bud < off || !listed_at[bud] || order_at[bud] != t)
                        begin
                            ok = 1'b0;
                            break;
                        end
                        t++;
                    end
                    if (ok)
                    begin
                        for (b = o; b < t; b++)
                            list_drop(off + (1 << b));
                        order_at[off] = t;
                        bytes_out += 16'(blk_bytes(t) - blk_bytes(o));
                        g.status = ST_OK;
                        g.offset = OFF_W'(off);
                        g.usable = 16'(blk_bytes(t) - hdr_len);
                    end
                end
            end
        end
        g.held = bytes_out;
        return g;
    endfunction

    // Offer one command beat, with an optional idle gap in front
    task automatic send_cmd(input logic [1:0] cmd, input int req, input int off);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = {4'b0, off[OFF_W-1:0], req[15:0], cmd};
        do
            @(posedge clk);
        while (!s_tready);
        grants_due.push_back(allocator_step(cmd, req[15:0], off[OFF_W-1:0]));
    endtask

    task automatic idle_line();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Wait out all pending results, then write the header length
    task automatic set_header(input int val);
        idle_line();
        wait (grants_due.size() == 0);
        repeat (60) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = val[4:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        hdr_len = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    // Check every result beat against the oldest grant
    always @(posedge clk)
    begin
        grant_t got;
        grant_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[43:0];
            if (grants_due.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                want = grants_due.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.offset != want.offset)
                    report_mismatch("result_offset", got.offset, want.offset);
                if (got.usable != want.usable)
                    report_mismatch("usable_bytes", got.usable, want.usable);
                if (got.held != want.held)
                    report_mismatch("bytes_in_use", got.held, want.held);
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (no_gaps || $urandom_range(0, 3) != 0)
                m_tready = 1'b1;
            else
            begin
                m_tready = 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : 1)
                    @(negedge clk);
            end
        end
    end

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 200);
        if (r < 95)
            return $urandom_range(0, 2000);
        if (r < 98)
            return $urandom_range(0, 32768);
        return $urandom_range(0, 65535);
    endfunction

    task automatic test_directed();
        int a;
        set_header(0);
        send_cmd(CMD_ALLOC, 0, 0);
        send_cmd(CMD_ALLOC, 32768, 0);
        send_cmd(CMD_ALLOC, 32769, 0);
        send_cmd(CMD_ALLOC, 65535, 1023);
        send_cmd(CMD_FREE, 0, 1023);
        send_cmd(CMD_BAD, 65535, 1023);
        send_cmd(CMD_GROW, 64, 0);
        send_cmd(CMD_GROW, 16, 0);
        send_cmd(CMD_ALLOC, 30, 0);
        a = live_blocks[live_blocks.size() - 1];
        send_cmd(CMD_GROW, 100, a);
        send_cmd(CMD_GROW, 65535, 0);
        send_cmd(CMD_FREE, 0, 0);
        send_cmd(CMD_FREE, 0, 0);
        send_cmd(CMD_FREE, 0, a);
        set_header(31);
        send_cmd(CMD_ALLOC, 32737, 0);
        send_cmd(CMD_ALLOC, 32738, 0);
        send_cmd(CMD_FREE, 0, 0);
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_FREE, 0, 0);
    endtask

    // Mostly well-formed traffic with some noise
    task automatic test_random(input int count);
        int r;
        int idx;
        int blk;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (live_blocks.size() > 0)
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                blk = live_blocks[idx];
            end
            else
                blk = $urandom_range(0, 1023);
            if (r < 10)
                send_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                         $urandom_range(0, 1023));
            else if (r < 50 - (live_blocks.size() > 24 ? 20 : 0))
                send_cmd(CMD_ALLOC, pick_size(), $urandom_range(0, 1023));
            else if (r < 85)
                send_cmd(CMD_FREE, $urandom_range(0, 65535), blk);
            else
                send_cmd(CMD_GROW, $urandom_range(0, 1) ? $urandom_range(0, 1000) : pick_size(),
                         blk);
        end
    endtask

    task automatic test_backpressure();
        idle_line();
        hold_req = 1'b1;
        test_random(40);
    endtask

    task automatic test_drain_pause();
        test_random(30);
        idle_line();
        wait (grants_due.size() == 0);
        no_gaps = 1'b1;
        test_random(150);
        no_gaps = 1'b0;
    endtask

    initial
    begin
        pool_reset();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        set_header(8);
        test_random(400);
        test_backpressure();
        set_header(0);
        test_random(250);
        test_drain_pause();
        set_header(31);
        test_random(250);
        set_header($urandom_range(1, 30));
        test_random(200);
        idle_line();
        wait (grants_due.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("buddy_block_allocator_top_test: done, clean");
        else
            $display("buddy_block_allocator_top_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
